>>> design/crp_pkg.sv
// Package for the collector record parser: item types, request and record codes.
// Used by the interfaces and by every module of the block; depends on nothing.
`default_nettype none

package crp_pkg;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_ARM  = 2'd2;

    // Record type in the top two bits of a head byte.
    localparam logic [1:0] REC_ENTER   = 2'b00;
    localparam logic [1:0] REC_CV      = 2'b01;
    localparam logic [1:0] REC_EXIT    = 2'b10;
    localparam logic [1:0] REC_UNKNOWN = 2'b11;

    // Result kinds.
    localparam logic [1:0] KIND_BLOCK   = 2'd0;
    localparam logic [1:0] KIND_CV      = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam int          COUNT_W       = 17;

    typedef enum logic [1:0] {
        PHASE_HEAD  = 2'd0,
        PHASE_DATA1 = 2'd1,
        PHASE_DATA2 = 2'd2,
        PHASE_SKIP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         data_byte;
        logic               last_byte;
        logic signed [15:0] base_pin;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [15:0] event_pin;
        logic [15:0]        loco_id;
        logic               entering;
        logic [7:0]         read_value;
    } res_item_t;

    // Outcome of one collector byte, handed from the parser to the top level.
    typedef struct packed {
        logic      valid;
        res_item_t item;
    } parse_res_t;

    // Requests from the top level to the pending-read timer.
    typedef struct packed {
        logic tick;
        logic arm;
        logic cv_taken;
    } timer_ctl_t;

endpackage

`default_nettype wire

>>> design/crp_if.sv
// Valid/ready channel interfaces for the collector record parser.
// Depends on crp_pkg for the payload types.
`default_nettype none

interface crp_req_if;
    logic              valid;
    logic              ready;
    crp_pkg::req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface crp_res_if;
    logic              valid;
    logic              ready;
    crp_pkg::res_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/crp_parser.sv
// Record parser: walks the collector buffer one byte per beat and forms results.
// Depends on crp_pkg.
`default_nettype none

module crp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_en,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic [15:0]        base_pin,
    input  wire logic               read_pending,
    output crp_pkg::parse_res_t     res,
    output logic                    cv_taken
);

    crp_pkg::phase_t phase_reg, phase_next;
    logic            is_block_reg, is_block_next;
    logic            exit_reg, exit_next;
    logic [5:0]      block_reg, block_next;
    logic [7:0]      loco_hi_reg, loco_hi_next;
    logic [15:0]     base_reg, base_next;
    logic [1:0]      rec_type;

    assign rec_type = data_byte[7:6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= crp_pkg::PHASE_HEAD;
            is_block_reg <= 1'b0;
            exit_reg     <= 1'b0;
            block_reg    <= '0;
            loco_hi_reg  <= '0;
            base_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            is_block_reg <= is_block_next;
            exit_reg     <= exit_next;
            block_reg    <= block_next;
            loco_hi_reg  <= loco_hi_next;
            base_reg     <= base_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        is_block_next = is_block_reg;
        exit_next     = exit_reg;
        block_next    = block_reg;
        loco_hi_next  = loco_hi_reg;
        base_next     = base_reg;
        res           = '0;
        cv_taken      = 1'b0;

        if (byte_en)
        begin
            unique case (phase_reg)
                crp_pkg::PHASE_HEAD:
                begin
                    if (rec_type == crp_pkg::REC_UNKNOWN)
                    begin
                        res.valid            = 1'b1;
                        res.item.result_kind = crp_pkg::KIND_UNKNOWN;
                        phase_next = last_byte ? crp_pkg::PHASE_HEAD : crp_pkg::PHASE_SKIP;
                    end
                    else
                    begin
                        is_block_next = (rec_type != crp_pkg::REC_CV);
                        if (rec_type != crp_pkg::REC_CV)
                        begin
                            exit_next  = (rec_type == crp_pkg::REC_EXIT);
                            block_next = data_byte[5:0];
                            base_next  = base_pin;
                        end
                        phase_next = last_byte ? crp_pkg::PHASE_HEAD : crp_pkg::PHASE_DATA1;
                    end
                end
                crp_pkg::PHASE_DATA1:
                begin
                    if (is_block_reg)
                    begin
                        loco_hi_next = data_byte;
                        phase_next = last_byte ? crp_pkg::PHASE_HEAD : crp_pkg::PHASE_DATA2;
                    end
                    else
                    begin
                        // A CV value only counts while a read is waiting for it.
                        if (read_pending)
                        begin
                            res.valid            = 1'b1;
                            res.item.result_kind = crp_pkg::KIND_CV;
                            res.item.read_value  = data_byte;
                            cv_taken             = 1'b1;
                        end
                        phase_next = crp_pkg::PHASE_HEAD;
                    end
                end
                crp_pkg::PHASE_DATA2:
                begin
                    res.valid            = 1'b1;
                    res.item.result_kind = crp_pkg::KIND_BLOCK;
                    res.item.event_pin   = base_reg + {10'd0, block_reg};
                    res.item.loco_id     = {loco_hi_reg, data_byte};
                    res.item.entering    = ~exit_reg;
                    phase_next           = crp_pkg::PHASE_HEAD;
                end
                crp_pkg::PHASE_SKIP:
                begin
                    if (last_byte)
                    begin
                        phase_next = crp_pkg::PHASE_HEAD;
                    end
                end
                default:
                begin
                    phase_next = crp_pkg::PHASE_HEAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/crp_read_timer.sv
// Pending CV read timer: armed by arm beats, advanced by tick beats, holds the limit.
// Depends on crp_pkg.
`default_nettype none

module crp_read_timer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire crp_pkg::timer_ctl_t ctl,
    output logic                    read_pending,
    output logic                    timeout
);

    logic                        pending_reg, pending_next;
    logic [crp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [15:0]                 limit_reg;
    logic [crp_pkg::COUNT_W-1:0] count_inc;

    assign read_pending = pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            count_reg   <= '0;
            limit_reg   <= crp_pkg::TIMEOUT_RESET;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // The count saturates rather than wrapping.
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        timeout      = 1'b0;

        if (ctl.arm)
        begin
            pending_next = 1'b1;
            count_next   = '0;
        end
        else if (ctl.tick && pending_reg)
        begin
            count_next = count_inc;
            if (count_inc > {{(crp_pkg::COUNT_W-16){1'b0}}, limit_reg})
            begin
                pending_next = 1'b0;
                timeout      = 1'b1;
            end
        end
        else if (ctl.cv_taken)
        begin
            pending_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> design/collector_record_parser.sv
// Collector record parser: one input beat per clock unless the result channel stalls,
// results in an output register. A beat waits in the input register; one that yields
// a result loads the result register as it leaves and is shown on the channel from then on.
// A stalled result channel holds the result register and, once the input register is also
// full, drops ready on the request channel. Configuration writes take effect the next cycle.
// Depends on crp_pkg, crp_if, crp_parser and crp_read_timer.
`default_nettype none

module collector_record_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    crp_req_if.sink          req,
    crp_res_if.source        res
);

    logic                  in_valid_reg;
    crp_pkg::req_item_t    in_item_reg;
    logic                  out_valid_reg;
    crp_pkg::res_item_t    out_item_reg;
    logic                  out_free;
    logic                  fire;
    logic                  byte_en;
    logic                  read_pending;
    logic                  cv_taken;
    logic                  timeout;
    crp_pkg::parse_res_t   parse_res;
    crp_pkg::timer_ctl_t   timer_ctl;
    crp_pkg::res_item_t    timeout_item;

    assign out_free  = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_item_reg;

    assign byte_en            = fire && (in_item_reg.req_type == crp_pkg::REQ_BYTE);
    assign timer_ctl.tick     = fire && (in_item_reg.req_type == crp_pkg::REQ_TICK);
    assign timer_ctl.arm      = fire && (in_item_reg.req_type == crp_pkg::REQ_ARM);
    assign timer_ctl.cv_taken = cv_taken;

    always_comb
    begin
        timeout_item             = '0;
        timeout_item.result_kind = crp_pkg::KIND_TIMEOUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (fire)
            begin
                out_valid_reg <= parse_res.valid || timeout;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg <= req.payload;
        end
        if (fire)
        begin
            out_item_reg <= timeout ? timeout_item : parse_res.item;
        end
    end

    crp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_en      (byte_en),
        .data_byte    (in_item_reg.data_byte),
        .last_byte    (in_item_reg.last_byte),
        .base_pin     (in_item_reg.base_pin),
        .read_pending (read_pending),
        .res          (parse_res),
        .cv_taken     (cv_taken)
    );

    crp_read_timer u_read_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .ctl          (timer_ctl),
        .read_pending (read_pending),
        .timeout      (timeout)
    );

endmodule

`default_nettype wire
